// File: hw/rtl/tlms_pkg.sv
// shared types and constants of the traffic light mode sequencer
package tlms_pkg;

	// light phases; PH_NONE marks no distance phase shown yet
	localparam logic [1:0] PH_RED  = 2'd0;
	localparam logic [1:0] PH_GRN  = 2'd1;
	localparam logic [1:0] PH_YEL  = 2'd2;
	localparam logic [1:0] PH_NONE = 2'd3;

	// operating modes
	localparam logic [1:0] MODE_CYC = 2'd0;
	localparam logic [1:0] MODE_EMG = 2'd1;
	localparam logic [1:0] MODE_DST = 2'd2;

	// lamp bit positions: red, yellow, green from the lowest bit up
	localparam logic [2:0] LAMP_OFF = 3'b000;
	localparam logic [2:0] LAMP_R   = 3'b001;
	localparam logic [2:0] LAMP_Y   = 3'b010;
	localparam logic [2:0] LAMP_G   = 3'b100;

	// input word kinds
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_CMD  = 1'b1;

	// command codes on the input word
	localparam logic [2:0] CMD_EMERGENCY = 3'd0;
	localparam logic [2:0] CMD_CLEAR_EMG = 3'd1;
	localparam logic [2:0] CMD_DISTANCE  = 3'd2;
	localparam logic [2:0] CMD_RESTART   = 3'd3;
	localparam logic [2:0] CMD_TOGGLE_PK = 3'd4;
	localparam logic [2:0] CMD_HOUR      = 3'd5;

	// configuration register indexes
	localparam logic [2:0] REG_OFFPEAK_RED   = 3'd0;
	localparam logic [2:0] REG_OFFPEAK_GREEN = 3'd1;
	localparam logic [2:0] REG_PEAK_RED      = 3'd2;
	localparam logic [2:0] REG_PEAK_GREEN    = 3'd3;
	localparam logic [2:0] REG_YELLOW        = 3'd4;
	localparam logic [2:0] REG_BLINK         = 3'd5;
	localparam logic [2:0] REG_NEAR          = 3'd6;

	// rush hour windows, from the low hour up to but not including the high one
	localparam logic [4:0] AM_RUSH_LO = 5'd8;
	localparam logic [4:0] AM_RUSH_HI = 5'd10;
	localparam logic [4:0] PM_RUSH_LO = 5'd17;
	localparam logic [4:0] PM_RUSH_HI = 5'd19;

	// queue between front and back
	localparam int QDEPTH = 2;

	// classified word kinds
	typedef enum logic [2:0] {
		K_TICK      = 3'd0,
		K_EMERGENCY = 3'd1,
		K_CLEAR_EMG = 3'd2,
		K_DISTANCE  = 3'd3,
		K_RESTART   = 3'd4,
		K_TOGGLE_PK = 3'd5,
		K_SET_PEAK  = 3'd6,
		K_NOP       = 3'd7
	} kind_t;

	// classified word as queued for the back end
	typedef struct packed {
		kind_t       kind;
		logic [9:0]  range_cm;
		logic        in_rush;
	} item_t;

	// configuration register set
	typedef struct packed {
		logic [15:0] offpeak_red_ticks;
		logic [15:0] offpeak_green_ticks;
		logic [15:0] peak_red_ticks;
		logic [15:0] peak_green_ticks;
		logic [15:0] yellow_ticks;
		logic [15:0] blink_ticks;
		logic [8:0]  near_cm;
	} cfg_t;

endpackage

// File: hw/rtl/traffic_light_mode_sequencer.sv
// top level: configuration registers, front end, queue and back end
// an accepted word is stored in the queue; the back end then pops it and registers its result word
// throughput: one word per cycle unless m_tready stalls; one sequencer step per word
// the two-entry queue absorbs words while the result register waits on m_tready
// reset: asynchronous, returns all timings to defaults, red lit, cycle mode, off-peak
// no clearing pass: the block accepts words in the first cycle after reset
module traffic_light_mode_sequencer #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // command[2:0], distance[12:3], hour[17:13], zeros
	input  logic        s_tuser,   // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // lamp_red, lamp_yellow, lamp_green, current_mode[4:3],
	                               // shown_phase_out[6:5], remaining_ticks[22:7], peak_active
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	tlms_pkg::cfg_t  cfg_q;
	tlms_pkg::item_t front_item;
	tlms_pkg::item_t head_item;
	logic            q_not_full;
	logic            q_not_empty;
	logic            q_pop;

	assign cfg_ready = 1'b1;
	assign s_tready  = q_not_full;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.offpeak_red_ticks   <= 16'd70;
			cfg_q.offpeak_green_ticks <= 16'd50;
			cfg_q.peak_red_ticks      <= 16'd30;
			cfg_q.peak_green_ticks    <= 16'd80;
			cfg_q.yellow_ticks        <= 16'd30;
			cfg_q.blink_ticks         <= 16'd5;
			cfg_q.near_cm             <= 9'd50;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tlms_pkg::REG_OFFPEAK_RED:   cfg_q.offpeak_red_ticks   <= cfg_data;
				tlms_pkg::REG_OFFPEAK_GREEN: cfg_q.offpeak_green_ticks <= cfg_data;
				tlms_pkg::REG_PEAK_RED:      cfg_q.peak_red_ticks      <= cfg_data;
				tlms_pkg::REG_PEAK_GREEN:    cfg_q.peak_green_ticks    <= cfg_data;
				tlms_pkg::REG_YELLOW:        cfg_q.yellow_ticks        <= cfg_data;
				tlms_pkg::REG_BLINK:         cfg_q.blink_ticks         <= cfg_data;
				tlms_pkg::REG_NEAR:          cfg_q.near_cm             <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// word classification
	tlms_front u_front (
		.in_op          (s_tuser),
		.in_command     (s_tdata[2:0]),
		.in_range_cm    (s_tdata[12:3]),
		.in_hour        (s_tdata[17:13]),
		.item           (front_item)
	);

	// decoupling queue
	tlms_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s_tvalid),
		.push_item (front_item),
		.not_full  (q_not_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head_item (head_item)
	);

	// sequencer
	tlms_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_not_empty),
		.q_item    (head_item),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_word  (m_tdata)
	);

endmodule

// File: hw/rtl/tlms_front.sv
// front end: classifies incoming words into queue entries
module tlms_front (
	input  logic                 in_op,
	input  logic [2:0]           in_command,
	input  logic [9:0]           in_range_cm,
	input  logic [4:0]           in_hour,
	output tlms_pkg::item_t      item
);

	logic in_am;
	logic in_pm;

	// peak window check done up front
	assign in_am = (in_hour >= tlms_pkg::AM_RUSH_LO) && (in_hour < tlms_pkg::AM_RUSH_HI);
	assign in_pm = (in_hour >= tlms_pkg::PM_RUSH_LO) && (in_hour < tlms_pkg::PM_RUSH_HI);

	// decode word kind
	always_comb begin
		item.range_cm = in_range_cm;
		item.in_rush  = in_am || in_pm;
		if (in_op == tlms_pkg::OP_TICK) begin
			item.kind = tlms_pkg::K_TICK;
		end else begin
			unique case (in_command)
				tlms_pkg::CMD_EMERGENCY: item.kind = tlms_pkg::K_EMERGENCY;
				tlms_pkg::CMD_CLEAR_EMG: item.kind = tlms_pkg::K_CLEAR_EMG;
				tlms_pkg::CMD_DISTANCE:  item.kind = tlms_pkg::K_DISTANCE;
				tlms_pkg::CMD_RESTART:   item.kind = tlms_pkg::K_RESTART;
				tlms_pkg::CMD_TOGGLE_PK: item.kind = tlms_pkg::K_TOGGLE_PK;
				tlms_pkg::CMD_HOUR:      item.kind = tlms_pkg::K_SET_PEAK;
				default:                 item.kind = tlms_pkg::K_NOP;
			endcase
		end
	end

endmodule

// File: hw/rtl/tlms_queue.sv
// short queue decoupling the front end from the back end
module tlms_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  tlms_pkg::item_t  push_item,
	output logic             not_full,
	input  logic             pop,
	output logic             not_empty,
	output tlms_pkg::item_t  head_item
);

	localparam int QAW = (tlms_pkg::QDEPTH > 1) ? $clog2(tlms_pkg::QDEPTH) : 1;
	localparam int CW  = $clog2(tlms_pkg::QDEPTH + 1);

	tlms_pkg::item_t  entry_q [tlms_pkg::QDEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign not_full  = (count_q != CW'(tlms_pkg::QDEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && not_full;
	assign do_pop    = pop && not_empty;
	assign head_item = entry_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(tlms_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(tlms_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: hw/rtl/tlms_back.sv
// back end: sequencer state, lamp logic and registered result word
module tlms_back #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tlms_pkg::cfg_t   cfg,
	input  logic             q_valid,
	input  tlms_pkg::item_t  q_item,
	output logic             q_pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [23:0]      out_word
);

	localparam int CMPW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	// sequencer state
	logic [1:0]             mode_q, prev_mode_q, phase_q, saved_phase_q;
	logic [1:0]             last_dist_q, shown_phase_q;
	logic [COUNT_WIDTH-1:0] elapsed_q, blink_cnt_q, saved_el_q, shown_el_q;
	logic                   blink_q, peak_q;
	logic [2:0]             lamps_q;
	logic                   out_valid_q;
	logic [23:0]            out_word_q;

	// next state
	logic [1:0]             mode_d, prev_mode_d, phase_d, saved_phase_d;
	logic [1:0]             last_dist_d, shown_phase_d, want;
	logic [COUNT_WIDTH-1:0] elapsed_d, blink_cnt_d, saved_el_d, shown_el_d;
	logic                   blink_d, peak_d;
	logic [2:0]             lamps_d;
	logic [15:0]            dur_shown;
	logic [15:0]            remaining;

	function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] c);
		bump = (c == CNT_MAX) ? CNT_MAX : c + 1'b1;
	endfunction

	function automatic logic [2:0] lamps_of(input logic [1:0] ph);
		priority if (ph == tlms_pkg::PH_GRN) lamps_of = tlms_pkg::LAMP_G;
		else if (ph == tlms_pkg::PH_YEL) lamps_of = tlms_pkg::LAMP_Y;
		else lamps_of = tlms_pkg::LAMP_R;
	endfunction

	function automatic logic [1:0] after(input logic [1:0] ph);
		priority if (ph == tlms_pkg::PH_RED) after = tlms_pkg::PH_GRN;
		else if (ph == tlms_pkg::PH_GRN) after = tlms_pkg::PH_YEL;
		else after = tlms_pkg::PH_RED;
	endfunction

	function automatic logic [15:0] dur_of(input logic [1:0] ph, input logic pk,
			input tlms_pkg::cfg_t c);
		priority if (ph == tlms_pkg::PH_GRN)
			dur_of = pk ? c.peak_green_ticks : c.offpeak_green_ticks;
		else if (ph == tlms_pkg::PH_YEL)
			dur_of = c.yellow_ticks;
		else
			dur_of = pk ? c.peak_red_ticks : c.offpeak_red_ticks;
	endfunction

	// take a word when the result register is free or being emptied
	assign q_pop     = q_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// distance classification
	always_comb begin
		priority if (q_item.range_cm < {1'b0, cfg.near_cm}) want = tlms_pkg::PH_GRN;
		else if (q_item.range_cm < {cfg.near_cm, 1'b0}) want = tlms_pkg::PH_YEL;
		else want = tlms_pkg::PH_RED;
	end

	// step of the sequencer for one word
	always_comb begin
		mode_d        = mode_q;
		prev_mode_d   = prev_mode_q;
		phase_d       = phase_q;
		saved_phase_d = saved_phase_q;
		last_dist_d   = last_dist_q;
		shown_phase_d = shown_phase_q;
		elapsed_d     = elapsed_q;
		blink_cnt_d   = blink_cnt_q;
		saved_el_d    = saved_el_q;
		shown_el_d    = shown_el_q;
		blink_d       = blink_q;
		peak_d        = peak_q;
		lamps_d       = lamps_q;
		unique case (q_item.kind)
			tlms_pkg::K_TICK: begin
				if (mode_q == tlms_pkg::MODE_EMG) begin
					// emergency: save position once, blink green
					if (prev_mode_q != tlms_pkg::MODE_EMG) begin
						saved_phase_d = phase_q;
						saved_el_d    = elapsed_q;
					end
					blink_cnt_d = bump(blink_cnt_q);
					if ((CMPW'(blink_cnt_d) >= CMPW'(cfg.blink_ticks)) ||
							(blink_cnt_d == CNT_MAX)) begin
						blink_cnt_d = '0;
						blink_d     = !blink_q;
						lamps_d     = blink_d ? tlms_pkg::LAMP_G : tlms_pkg::LAMP_OFF;
					end
					prev_mode_d = tlms_pkg::MODE_EMG;
				end else begin
					// leaving emergency restores the saved position
					if (prev_mode_q == tlms_pkg::MODE_EMG) begin
						phase_d     = saved_phase_q;
						elapsed_d   = saved_el_q;
						blink_d     = 1'b0;
						blink_cnt_d = '0;
						lamps_d     = lamps_of(saved_phase_q);
					end
					if (mode_q == tlms_pkg::MODE_DST) begin
						if (want != last_dist_q) begin
							lamps_d     = lamps_of(want);
							last_dist_d = want;
						end
						prev_mode_d = tlms_pkg::MODE_DST;
					end else begin
						// after distance mode resume from the published position
						if (prev_mode_q == tlms_pkg::MODE_DST) begin
							phase_d   = shown_phase_q;
							elapsed_d = shown_el_q;
							lamps_d   = lamps_of(shown_phase_q);
						end
						elapsed_d     = bump(elapsed_d);
						shown_phase_d = phase_d;
						shown_el_d    = elapsed_d;
						if ((CMPW'(elapsed_d) >= CMPW'(dur_of(phase_d, peak_q, cfg))) ||
								(elapsed_d == CNT_MAX)) begin
							phase_d   = after(phase_d);
							elapsed_d = '0;
							lamps_d   = lamps_of(phase_d);
						end
						prev_mode_d = mode_q;
					end
				end
			end
			tlms_pkg::K_EMERGENCY: mode_d = tlms_pkg::MODE_EMG;
			tlms_pkg::K_CLEAR_EMG: begin
				if (mode_q == tlms_pkg::MODE_EMG) begin
					mode_d = tlms_pkg::MODE_CYC;
				end
			end
			tlms_pkg::K_DISTANCE: mode_d = tlms_pkg::MODE_DST;
			tlms_pkg::K_RESTART: begin
				mode_d        = tlms_pkg::MODE_CYC;
				shown_phase_d = tlms_pkg::PH_RED;
				shown_el_d    = '0;
			end
			tlms_pkg::K_TOGGLE_PK: peak_d = !peak_q;
			tlms_pkg::K_SET_PEAK:  peak_d = q_item.in_rush;
			default: ;
		endcase
	end

	// published remaining time, saturated at zero
	always_comb begin
		dur_shown = dur_of(shown_phase_d, peak_d, cfg);
		if (CMPW'(shown_el_d) < CMPW'(dur_shown)) begin
			remaining = 16'(CMPW'(dur_shown) - CMPW'(shown_el_d));
		end else begin
			remaining = '0;
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= tlms_pkg::MODE_CYC;
			prev_mode_q   <= tlms_pkg::MODE_CYC;
			phase_q       <= tlms_pkg::PH_RED;
			saved_phase_q <= tlms_pkg::PH_RED;
			last_dist_q   <= tlms_pkg::PH_NONE;
			shown_phase_q <= tlms_pkg::PH_RED;
			elapsed_q     <= '0;
			blink_cnt_q   <= '0;
			saved_el_q    <= '0;
			shown_el_q    <= '0;
			blink_q       <= 1'b0;
			peak_q        <= 1'b0;
			lamps_q       <= tlms_pkg::LAMP_R;
		end else if (q_pop) begin
			mode_q        <= mode_d;
			prev_mode_q   <= prev_mode_d;
			phase_q       <= phase_d;
			saved_phase_q <= saved_phase_d;
			last_dist_q   <= last_dist_d;
			shown_phase_q <= shown_phase_d;
			elapsed_q     <= elapsed_d;
			blink_cnt_q   <= blink_cnt_d;
			saved_el_q    <= saved_el_d;
			shown_el_q    <= shown_el_d;
			blink_q       <= blink_d;
			peak_q        <= peak_d;
			lamps_q       <= lamps_d;
		end
	end

	// result word valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result word payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_word_q <= {peak_d, remaining, shown_phase_d, mode_d, lamps_d};
		end
	end

endmodule

// File: tb/tb_top.sv
// self-checking testbench of the traffic light mode sequencer
module tb_top;
	import tlms_pkg::*;

	// spare command codes that the block must ignore
	localparam logic [2:0] CMD_SPARE6 = 3'd6;
	localparam logic [2:0] CMD_SPARE7 = 3'd7;
	localparam logic [15:0] COUNT_TOP = 16'hFFFF;
	localparam int unsigned PHASE_WORDS = 320;

	// one input word: op in tuser, the rest in tdata from bit 0 up
	typedef struct packed {
		logic        op;
		logic [4:0]  hour;
		logic [9:0]  range_cm;
		logic [2:0]  command;
	} road_word_t;

	// one result word, laid out as on m_tdata
	typedef struct packed {
		logic        peak;
		logic [15:0] remaining;
		logic [1:0]  phase;
		logic [1:0]  mode;
		logic        green;
		logic        yellow;
		logic        red;
	} lights_t;

	typedef struct packed {
		logic [2:0]  index;
		logic [15:0] data;
	} reg_write_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;    // command[2:0], distance[12:3], hour[17:13], zeros
	logic        s_tuser = 1'b0;  // op
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;         // lamp_red, lamp_yellow, lamp_green, current_mode[4:3],
	                              // shown_phase_out[6:5], remaining_ticks[22:7], peak_active
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	road_word_t  words_to_send[$];
	lights_t     lights_due[$];
	reg_write_t  reg_writes[$];

	int unsigned tx_wait, tx_calm, rx_wait, rx_calm;
	int unsigned results_seen = 0;
	int unsigned mismatches = 0;

	// predicted sequencer state
	cfg_t        timing;
	logic [1:0]  mode_now, mode_last, run_phase, held_phase, dist_phase, pub_phase;
	logic [15:0] run_count, blink_count, held_count, pub_count;
	logic        green_blink, peak_on;
	logic [2:0]  lamps;

	traffic_light_mode_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	// prediction helpers
	function automatic logic [15:0] count_up(logic [15:0] c);
		return (c == COUNT_TOP) ? c : c + 16'd1;
	endfunction

	function logic [15:0] phase_length(logic [1:0] ph);
		if (ph == PH_GRN)
			return peak_on ? timing.peak_green_ticks : timing.offpeak_green_ticks;
		if (ph == PH_YEL)
			return timing.yellow_ticks;
		return peak_on ? timing.peak_red_ticks : timing.offpeak_red_ticks;
	endfunction

	function automatic logic [2:0] lamps_for(logic [1:0] ph);
		if (ph == PH_GRN) return LAMP_G;
		if (ph == PH_YEL) return LAMP_Y;
		return LAMP_R;
	endfunction

	function automatic logic [1:0] phase_after(logic [1:0] ph);
		if (ph == PH_RED) return PH_GRN;
		if (ph == PH_GRN) return PH_YEL;
		return PH_RED;
	endfunction

	task lights_reset();
		timing.offpeak_red_ticks   = 16'd70;
		timing.offpeak_green_ticks = 16'd50;
		timing.peak_red_ticks      = 16'd30;
		timing.peak_green_ticks    = 16'd80;
		timing.yellow_ticks        = 16'd30;
		timing.blink_ticks         = 16'd5;
		timing.near_cm             = 9'd50;
		mode_now    = MODE_CYC;
		mode_last   = MODE_CYC;
		run_phase   = PH_RED;
		run_count   = '0;
		green_blink = 1'b0;
		blink_count = '0;
		held_phase  = PH_RED;
		held_count  = '0;
		dist_phase  = PH_NONE;
		pub_phase   = PH_RED;
		pub_count   = '0;
		peak_on     = 1'b0;
		lamps       = LAMP_R;
	endtask

	// advance the predicted state by one word and form the expected result
	task sequence_step(input road_word_t w, output lights_t res);
		logic [1:0]  want_phase;
		logic [15:0] dur;
		int unsigned span, near;
		span = 32'(w.range_cm);
		near = 32'(timing.near_cm);
		if (w.op == OP_TICK) begin
			if (mode_now == MODE_EMG) begin
				// emergency: keep the cycle position, blink green
				if (mode_last != MODE_EMG) begin
					held_phase = run_phase;
					held_count = run_count;
				end
				blink_count = count_up(blink_count);
				if (blink_count >= timing.blink_ticks || blink_count == COUNT_TOP) begin
					blink_count = '0;
					green_blink = ~green_blink;
					lamps = green_blink ? LAMP_G : LAMP_OFF;
				end
				mode_last = MODE_EMG;
			end else begin
				// back from emergency: restore the cycle position
				if (mode_last == MODE_EMG) begin
					run_phase = held_phase;
					run_count = held_count;
					green_blink = 1'b0;
					blink_count = '0;
					lamps = lamps_for(run_phase);
				end
				if (mode_now == MODE_DST) begin
					if (span < near) want_phase = PH_GRN;
					else if (span < 2 * near) want_phase = PH_YEL;
					else want_phase = PH_RED;
					if (want_phase != dist_phase) begin
						lamps = lamps_for(want_phase);
						dist_phase = want_phase;
					end
					mode_last = MODE_DST;
				end else begin
					// first cycle tick after distance mode picks up the published state
					if (mode_last == MODE_DST) begin
						run_phase = pub_phase;
						run_count = pub_count;
						lamps = lamps_for(run_phase);
					end
					run_count = count_up(run_count);
					pub_phase = run_phase;
					pub_count = run_count;
					if (run_count >= phase_length(run_phase) || run_count == COUNT_TOP) begin
						run_phase = phase_after(run_phase);
						run_count = '0;
						lamps = lamps_for(run_phase);
					end
					mode_last = mode_now;
				end
			end
		end else begin
			case (w.command)
				CMD_EMERGENCY: mode_now = MODE_EMG;
				CMD_CLEAR_EMG: if (mode_now == MODE_EMG) mode_now = MODE_CYC;
				CMD_DISTANCE:  mode_now = MODE_DST;
				CMD_RESTART: begin
					mode_now = MODE_CYC;
					pub_phase = PH_RED;
					pub_count = '0;
				end
				CMD_TOGGLE_PK: peak_on = ~peak_on;
				CMD_HOUR: peak_on = (w.hour >= AM_RUSH_LO && w.hour < AM_RUSH_HI) ||
				                    (w.hour >= PM_RUSH_LO && w.hour < PM_RUSH_HI);
				default: ;
			endcase
		end
		dur = phase_length(pub_phase);
		res.remaining = (pub_count < dur) ? dur - pub_count : 16'd0;
		res.red    = lamps[0];
		res.yellow = lamps[1];
		res.green  = lamps[2];
		res.mode   = mode_now;
		res.phase  = pub_phase;
		res.peak   = peak_on;
	endtask

	task compare_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// gap length for either side: mostly none, some short, a few long
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic road_word_t make_word(logic op, logic [2:0] cmd, logic [9:0] span,
	                                         logic [4:0] hour);
		road_word_t w;
		w.op = op;
		w.command = cmd;
		w.range_cm = span;
		w.hour = hour;
		return w;
	endfunction

	// random word, distances clustered on the thresholds
	function automatic road_word_t random_word(logic [8:0] near);
		road_word_t w;
		w.command = 3'($urandom_range(0, 7));
		w.hour = 5'($urandom_range(0, 31));
		case ($urandom_range(0, 5))
			0: w.range_cm = {1'b0, near} - 10'd1;
			1: w.range_cm = {1'b0, near};
			2: w.range_cm = {near, 1'b0} - 10'd1;
			3: w.range_cm = {near, 1'b0};
			default: w.range_cm = 10'($urandom_range(0, 1023));
		endcase
		if ($urandom_range(0, 99) < 70) begin
			w.op = OP_TICK;
		end else begin
			w.op = OP_CMD;
			case ($urandom_range(0, 13))
				0, 1:    w.command = CMD_EMERGENCY;
				2, 3, 4: w.command = CMD_CLEAR_EMG;
				5, 6:    w.command = CMD_DISTANCE;
				7, 8:    w.command = CMD_RESTART;
				9:       w.command = CMD_TOGGLE_PK;
				10, 11:  w.command = CMD_HOUR;
				12:      w.command = CMD_SPARE6;
				default: w.command = CMD_SPARE7;
			endcase
		end
		return w;
	endfunction

	// timing set of each random phase
	function automatic cfg_t timing_for(int unsigned k);
		cfg_t t;
		case (k)
			0: begin
				t.offpeak_red_ticks   = 16'($urandom_range(1, 6));
				t.offpeak_green_ticks = 16'($urandom_range(1, 6));
				t.peak_red_ticks      = 16'($urandom_range(1, 6));
				t.peak_green_ticks    = 16'($urandom_range(1, 6));
				t.yellow_ticks        = 16'($urandom_range(1, 4));
				t.blink_ticks         = 16'($urandom_range(1, 3));
				t.near_cm             = 9'($urandom_range(20, 300));
			end
			1: begin
				// zero durations end a phase on every tick
				t.offpeak_red_ticks   = 16'($urandom_range(0, 1));
				t.offpeak_green_ticks = 16'd0;
				t.peak_red_ticks      = 16'd1;
				t.peak_green_ticks    = 16'($urandom_range(0, 1));
				t.yellow_ticks        = 16'd0;
				t.blink_ticks         = 16'd0;
				t.near_cm             = 9'd1;
			end
			2: begin
				t.offpeak_red_ticks   = 16'hFFFF;
				t.offpeak_green_ticks = 16'hFFFF;
				t.peak_red_ticks      = 16'($urandom_range(1, 4));
				t.peak_green_ticks    = 16'd3;
				t.yellow_ticks        = 16'hFFFF;
				t.blink_ticks         = 16'hFFFF;
				t.near_cm             = 9'd511;
			end
			3: begin
				t.offpeak_red_ticks   = 16'($urandom_range(1, 12));
				t.offpeak_green_ticks = 16'($urandom_range(1, 12));
				t.peak_red_ticks      = 16'($urandom_range(1, 12));
				t.peak_green_ticks    = 16'($urandom_range(1, 12));
				t.yellow_ticks        = 16'($urandom_range(1, 12));
				t.blink_ticks         = 16'($urandom_range(1, 6));
				t.near_cm             = 9'($urandom_range(1, 511));
			end
			4: begin
				t.offpeak_red_ticks   = 16'($urandom_range(1, 5));
				t.offpeak_green_ticks = 16'($urandom_range(1, 5));
				t.peak_red_ticks      = 16'($urandom_range(1, 5));
				t.peak_green_ticks    = 16'($urandom_range(1, 5));
				t.yellow_ticks        = 16'($urandom_range(1, 3));
				t.blink_ticks         = 16'($urandom_range(2, 4));
				t.near_cm             = 9'd511;
			end
			default: begin
				t.offpeak_red_ticks   = 16'($urandom_range(1, 65535));
				t.offpeak_green_ticks = 16'($urandom_range(1, 4));
				t.peak_red_ticks      = 16'($urandom_range(1, 4));
				t.peak_green_ticks    = 16'($urandom_range(1, 65535));
				t.yellow_ticks        = 16'($urandom_range(1, 4));
				t.blink_ticks         = 16'($urandom_range(1, 8));
				t.near_cm             = 9'($urandom_range(1, 511));
			end
		endcase
		return t;
	endfunction

	// sender: offers queued words, predicts each accepted one
	always @(posedge clk or negedge arst_n) begin : sender
		road_word_t w;
		lights_t due;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			tx_wait <= 0;
			tx_calm <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				sequence_step(road_word_t'({s_tuser, s_tdata[17:0]}), due);
				lights_due.push_back(due);
			end
			if (!s_tvalid || s_tready) begin
				if (tx_wait != 0 || words_to_send.size() == 0) begin
					s_tvalid <= 1'b0;
					if (tx_wait != 0) tx_wait <= tx_wait - 1;
				end else begin
					w = words_to_send.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= w.op;
					s_tdata <= {6'd0, w[17:0]};
					if (tx_calm != 0) begin
						tx_wait <= 0;
						tx_calm <= tx_calm - 1;
					end else begin
						tx_wait <= pick_gap();
						if ($urandom_range(0, 99) < 3) tx_calm <= $urandom_range(20, 80);
					end
				end
			end
		end
	end

	// receiver: random stalls, long hold-offs, result checking
	always @(posedge clk or negedge arst_n) begin : receiver
		lights_t got, want;
		logic hold_now;
		int unsigned gap;
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_wait <= 0;
			rx_calm <= 0;
		end else begin
			hold_now = 1'b0;
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				results_seen++;
				hold_now = (results_seen == 400 || results_seen == 1500);
				if (lights_due.size() == 0) begin
					$error("result word %h with nothing expected", m_tdata);
					mismatches++;
				end else begin
					want = lights_due.pop_front();
					compare_field("lamp_red", 32'(want.red), 32'(got.red));
					compare_field("lamp_yellow", 32'(want.yellow), 32'(got.yellow));
					compare_field("lamp_green", 32'(want.green), 32'(got.green));
					compare_field("current_mode", 32'(want.mode), 32'(got.mode));
					compare_field("shown_phase_out", 32'(want.phase), 32'(got.phase));
					compare_field("remaining_ticks", 32'(want.remaining),
					              32'(got.remaining));
					compare_field("peak_active", 32'(want.peak), 32'(got.peak));
				end
			end
			if (hold_now) begin
				// long hold-off so that the block backs up onto its input
				m_tready <= 1'b0;
				rx_wait <= 120;
			end else if (rx_wait != 0) begin
				m_tready <= 1'b0;
				rx_wait <= rx_wait - 1;
			end else if (rx_calm != 0) begin
				m_tready <= 1'b1;
				rx_calm <= rx_calm - 1;
			end else begin
				gap = pick_gap();
				if (gap == 0) begin
					m_tready <= 1'b1;
					if ($urandom_range(0, 99) < 4) rx_calm <= $urandom_range(30, 100);
				end else begin
					m_tready <= 1'b0;
					rx_wait <= gap - 1;
				end
			end
		end
	end

	// configuration channel
	always @(posedge clk or negedge arst_n) begin : reg_port
		reg_write_t r;
		if (!arst_n) begin
			cfg_valid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_OFFPEAK_RED:   timing.offpeak_red_ticks = cfg_data;
					REG_OFFPEAK_GREEN: timing.offpeak_green_ticks = cfg_data;
					REG_PEAK_RED:      timing.peak_red_ticks = cfg_data;
					REG_PEAK_GREEN:    timing.peak_green_ticks = cfg_data;
					REG_YELLOW:        timing.yellow_ticks = cfg_data;
					REG_BLINK:         timing.blink_ticks = cfg_data;
					REG_NEAR:          timing.near_cm = cfg_data[8:0];
					default: ;
				endcase
			end
			if (!cfg_valid || cfg_ready) begin
				if (reg_writes.size() != 0) begin
					r = reg_writes.pop_front();
					cfg_valid <= 1'b1;
					cfg_index <= r.index;
					cfg_data <= r.data;
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	// wait until every queued word has been answered and the block is quiet
	task automatic wait_drained();
		while (words_to_send.size() != 0 || s_tvalid || lights_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_timing(input cfg_t t);
		reg_writes.push_back({REG_OFFPEAK_RED, t.offpeak_red_ticks});
		reg_writes.push_back({REG_OFFPEAK_GREEN, t.offpeak_green_ticks});
		reg_writes.push_back({REG_PEAK_RED, t.peak_red_ticks});
		reg_writes.push_back({REG_PEAK_GREEN, t.peak_green_ticks});
		reg_writes.push_back({REG_YELLOW, t.yellow_ticks});
		reg_writes.push_back({REG_BLINK, t.blink_ticks});
		reg_writes.push_back({REG_NEAR, {7'd0, t.near_cm}});
		while (reg_writes.size() != 0 || cfg_valid) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// stimulus
	initial begin : stimulus
		cfg_t t;
		int unsigned split;
		lights_reset();
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// reset timings, hour window edges and peak toggle
		words_to_send.push_back(make_word(OP_TICK, CMD_EMERGENCY, 10'd0, 5'd0));
		words_to_send.push_back(make_word(OP_CMD, CMD_HOUR, 10'd1023, 5'd8));
		words_to_send.push_back(make_word(OP_CMD, CMD_HOUR, 10'd0, 5'd10));
		words_to_send.push_back(make_word(OP_CMD, CMD_HOUR, 10'd0, 5'd17));
		words_to_send.push_back(make_word(OP_CMD, CMD_HOUR, 10'd0, 5'd19));
		words_to_send.push_back(make_word(OP_CMD, CMD_HOUR, 10'd0, 5'd31));
		words_to_send.push_back(make_word(OP_CMD, CMD_TOGGLE_PK, 10'd0, 5'd0));
		words_to_send.push_back(make_word(OP_TICK, CMD_SPARE7, 10'd1023, 5'd31));
		wait_drained();

		// short timings: emergency, clears, distance thresholds, spare codes, restart
		t.offpeak_red_ticks   = 16'd2;
		t.offpeak_green_ticks = 16'd2;
		t.peak_red_ticks      = 16'd1;
		t.peak_green_ticks    = 16'd3;
		t.yellow_ticks        = 16'd1;
		t.blink_ticks         = 16'd1;
		t.near_cm             = 9'd50;
		load_timing(t);
		words_to_send.push_back(make_word(OP_TICK, CMD_EMERGENCY, 10'd0, 5'd0));
		words_to_send.push_back(make_word(OP_TICK, CMD_EMERGENCY, 10'd0, 5'd0));
		words_to_send.push_back(make_word(OP_CMD, CMD_EMERGENCY, 10'd0, 5'd0));
		words_to_send.push_back(make_word(OP_TICK, CMD_EMERGENCY, 10'd0, 5'd0));
		words_to_send.push_back(make_word(OP_TICK, CMD_EMERGENCY, 10'd0, 5'd0));
		words_to_send.push_back(make_word(OP_CMD, CMD_CLEAR_EMG, 10'd0, 5'd0));
		words_to_send.push_back(make_word(OP_CMD, CMD_CLEAR_EMG, 10'd0, 5'd0));
		words_to_send.push_back(make_word(OP_CMD, CMD_DISTANCE, 10'd0, 5'd0));
		words_to_send.push_back(make_word(OP_TICK, CMD_EMERGENCY, 10'd0, 5'd0));
		words_to_send.push_back(make_word(OP_TICK, CMD_EMERGENCY, 10'd49, 5'd0));
		words_to_send.push_back(make_word(OP_TICK, CMD_EMERGENCY, 10'd50, 5'd0));
		words_to_send.push_back(make_word(OP_TICK, CMD_EMERGENCY, 10'd99, 5'd0));
		words_to_send.push_back(make_word(OP_TICK, CMD_EMERGENCY, 10'd100, 5'd0));
		words_to_send.push_back(make_word(OP_TICK, CMD_EMERGENCY, 10'd1023, 5'd0));
		words_to_send.push_back(make_word(OP_CMD, CMD_SPARE6, 10'd0, 5'd0));
		words_to_send.push_back(make_word(OP_CMD, CMD_SPARE7, 10'd0, 5'd0));
		words_to_send.push_back(make_word(OP_CMD, CMD_RESTART, 10'd0, 5'd0));
		words_to_send.push_back(make_word(OP_TICK, CMD_EMERGENCY, 10'd0, 5'd0));
		words_to_send.push_back(make_word(OP_TICK, CMD_EMERGENCY, 10'd0, 5'd0));
		wait_drained();

		// random phases, each under its own timing set, with a drain part way
		for (int k = 0; k < 6; k++) begin
			t = timing_for(k);
			load_timing(t);
			split = $urandom_range(100, 220);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (n == split) wait_drained();
				words_to_send.push_back(random_word(t.near_cm));
			end
			wait_drained();
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("[traffic_light_mode_sequencer] OK");
		else
			$display("[traffic_light_mode_sequencer] ERROR");
		$finish;
	end

	// run limit
	initial begin
		#8000000;
		$display("[traffic_light_mode_sequencer] ERROR");
		$finish;
	end

endmodule
